// ===== hw/rtl/u8dec_pkg.sv =====
// Package for the lenient UTF-8 decoder: the job passed from front to back,
// byte masks and the lead-byte classifier.
// No dependencies.
package u8dec_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned JobSlot = 4;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;

  localparam logic [CpW-1:0] SUPP_LO = 21'h010000;
  localparam logic [CpW-1:0] SUPP_HI = 21'h10FFFF;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [1:0] UNITS_ONE = 2'd1;
  localparam logic [1:0] UNITS_TWO = 2'd2;

  // one byte's worth of results: a decoded code point, or up to four single bytes
  typedef struct packed {
    logic                     decoded;
    logic [CpW-1:0]           cp;
    logic [2:0]               used;
    logic [JobSlot-1:0][7:0]  bytes;
    logic [2:0]               cnt;
    logic                     eos;
  } job_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_NONE;
    if ((b & LEAD2_MASK) == LEAD2_VAL) len = LEN_2;
    else if ((b & LEAD3_MASK) == LEAD3_VAL) len = LEN_3;
    else if ((b & LEAD4_MASK) == LEAD4_VAL) len = LEN_4;
    return len;
  endfunction

endpackage

// ===== hw/rtl/u8dec_in_if.sv =====
// Input channel of the UTF-8 decoder: one raw byte and its end-of-string mark.
// Depends on nothing.
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

// ===== hw/rtl/u8dec_out_if.sv =====
// Result channel of the UTF-8 decoder: one code point word per handshake.
// Depends on nothing.
interface u8dec_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  utf16_units;
  logic        raw_fallback;
  logic [2:0]  bytes_used;
  logic        last_of_run;
  logic        string_done;

  modport source (output valid, output code_point, output utf16_units,
                  output raw_fallback, output bytes_used, output last_of_run,
                  output string_done, input ready);
  modport sink   (input valid, input code_point, input utf16_units,
                  input raw_fallback, input bytes_used, input last_of_run,
                  input string_done, output ready);
endinterface

// ===== hw/rtl/u8dec_front.sv =====
// Front of the UTF-8 decoder: holds the open sequence and turns the bytes
// into jobs for the back. Depends on u8dec_pkg and u8dec_in_if.
module u8dec_front (
  input  logic           clk,
  input  logic           rst_n,
  u8dec_in_if.sink       in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output u8dec_pkg::job_t job
);
  import u8dec_pkg::*;

  logic [7:0] held_r   [3];
  logic [7:0] held_nxt [3];
  logic [1:0] hc_r, hc_nxt;
  logic [2:0] exp_r, exp_nxt;

  logic [7:0] b;
  logic       eos;
  logic       is_cont;
  logic [2:0] len_b;
  logic       fresh_emit;
  logic       complete;
  logic       accept;

  assign b          = in_ch.byte_in;
  assign eos        = in_ch.end_of_string;
  assign is_cont    = (b & CONT_MASK) == CONT_VAL;
  assign len_b      = lead_length(b);
  assign fresh_emit = (len_b == LEN_NONE) || eos;
  assign complete   = (hc_r != 2'd0) && is_cont && (({1'b0, hc_r} + 3'd1) == exp_r);
  assign accept     = in_ch.valid && job_ready;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid && (job.cnt != 3'd0);

  // assemble the code point from the held lead and continuations
  always_comb begin
    case (exp_r)
      LEN_2:   job.cp = {10'd0, held_r[0][4:0], b[5:0]};
      LEN_3:   job.cp = {5'd0, held_r[0][3:0], held_r[1][5:0], b[5:0]};
      default: job.cp = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], b[5:0]};
    endcase
  end

  // flush slots: held bytes first, then the new byte
  always_comb begin
    for (int k = 0; k < JobSlot; k++) begin
      job.bytes[k] = (k < 3 && 2'(k) < hc_r) ? held_r[k < 3 ? k : 0] : b;
    end
  end

  // classify the byte and update the open sequence
  always_comb begin
    job.decoded = 1'b0;
    job.used    = exp_r;
    job.cnt     = 3'd0;
    job.eos     = eos;
    held_nxt    = held_r;
    hc_nxt      = hc_r;
    exp_nxt     = exp_r;
    if (hc_r != 2'd0) begin
      if (is_cont) begin
        priority if (complete) begin
          job.decoded = 1'b1;
          job.cnt     = 3'd1;
          hc_nxt      = 2'd0;
          exp_nxt     = LEN_NONE;
        end else if (eos || hc_r == 2'd3) begin
          job.cnt = {1'b0, hc_r} + 3'd1;
          hc_nxt  = 2'd0;
          exp_nxt = LEN_NONE;
        end else begin
          held_nxt[hc_r] = b;
          hc_nxt         = hc_r + 2'd1;
        end
      end else begin
        job.cnt = {1'b0, hc_r} + {2'd0, fresh_emit};
        if (fresh_emit) begin
          hc_nxt  = 2'd0;
          exp_nxt = LEN_NONE;
        end else begin
          held_nxt[0] = b;
          hc_nxt      = 2'd1;
          exp_nxt     = len_b;
        end
      end
    end else begin
      job.cnt = {2'd0, fresh_emit};
      if (!fresh_emit) begin
        held_nxt[0] = b;
        hc_nxt      = 2'd1;
        exp_nxt     = len_b;
      end
    end
  end

  // held bytes are payload, count and length are control
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r  <= 2'd0;
      exp_r <= LEN_NONE;
    end else if (accept) begin
      hc_r  <= hc_nxt;
      exp_r <= exp_nxt;
    end
  end

  a_open_seq_short: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> ((exp_r == LEN_2 || exp_r == LEN_3 || exp_r == LEN_4)
                        && ({1'b0, hc_r} < exp_r)))
    else $error("open sequence longer than its lead byte allows");

  a_idle_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r == 2'd0) |-> (exp_r == LEN_NONE))
    else $error("expected length kept with nothing held");

  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job.cnt <= 3'd4 && (!job.decoded || job.cnt == 3'd1)))
    else $error("job result count out of range");

  a_eos_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eos) |=> (hc_r == 2'd0))
    else $error("sequence left open after end of string");

endmodule

// ===== hw/rtl/u8dec_queue.sv =====
// Short job queue between the decoder front and back.
// Depends on u8dec_pkg.
module u8dec_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  u8dec_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output u8dec_pkg::job_t pop_job
);
  import u8dec_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) + CW'($past(push)) - CW'($past(pop))))
    else $error("queue fill count does not follow push and pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/u8dec_back.sv =====
// Back of the UTF-8 decoder (u8dec_pkg, u8dec_out_if): steps through
// each job, registering a result word per cycle while out_ch is ready.
module u8dec_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  u8dec_pkg::job_t job,
  u8dec_out_if.source     out_ch
);
  import u8dec_pkg::*;

  logic [1:0]     idx_r;
  logic           out_valid_r;
  logic [CpW-1:0] cp_r;
  logic [1:0]     units_r;
  logic           raw_r;
  logic [2:0]     used_r;
  logic           last_r;
  logic           done_r;

  logic [7:0]     sel_byte;
  logic [CpW-1:0] cp_nxt;
  logic [1:0]     units_nxt;
  logic           raw_nxt;
  logic [2:0]     used_nxt;
  logic           last_nxt;
  logic           load;

  assign load      = job_valid && (!out_valid_r || out_ch.ready);
  assign job_ready = load && last_nxt;
  assign sel_byte  = job.bytes[idx_r];

  // pick the result word for the current slot
  always_comb begin
    if (job.decoded) begin
      cp_nxt   = job.cp;
      raw_nxt  = 1'b0;
      used_nxt = job.used;
      last_nxt = 1'b1;
    end else begin
      cp_nxt   = {13'd0, sel_byte};
      raw_nxt  = sel_byte[7];
      used_nxt = 3'd1;
      last_nxt = ({1'b0, idx_r} + 3'd1) == job.cnt;
    end
    units_nxt = (cp_nxt >= SUPP_LO && cp_nxt <= SUPP_HI) ? UNITS_TWO : UNITS_ONE;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r    <= cp_nxt;
      units_r <= units_nxt;
      raw_r   <= raw_nxt;
      used_r  <= used_nxt;
      last_r  <= last_nxt;
      done_r  <= last_nxt && job.eos;
    end
  end

  // slot index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= last_nxt ? 2'd0 : idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = cp_r;
  assign out_ch.utf16_units  = units_r;
  assign out_ch.raw_fallback = raw_r;
  assign out_ch.bytes_used   = used_r;
  assign out_ch.last_of_run  = last_r;
  assign out_ch.string_done  = done_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && !job.decoded) |-> ({1'b0, idx_r} < job.cnt))
    else $error("slot index past the end of the job");

  a_decoded_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job.decoded) |-> (idx_r == 2'd0))
    else $error("decoded job entered mid-run");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("string end flagged on a word that is not last of its run");

  a_raw_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && raw_r) |-> (used_r == 3'd1 && units_r == UNITS_ONE))
    else $error("raw fallback word with more than one byte");

endmodule

// ===== hw/rtl/utf8_lenient_decoder_core.sv =====
// Top level of the lenient UTF-8 decoder: front, job queue and back.
// Depends on u8dec_pkg, u8dec_in_if, u8dec_out_if and the u8dec_* modules.
//
//  channel  | direction | words
//  in_ch    | in        | byte_in, end_of_string
//  out_ch   | out       | code_point, utf16_units, raw_fallback, bytes_used,
//           |           | last_of_run, string_done
//
// One byte is taken per cycle while the job queue has room; the front
// classifies it in that cycle. The back sends one result word per cycle while
// out_ch is ready, so a byte that flushes a held sequence yields up to four
// words, absorbed by the QUEUE_DEPTH-entry queue. A byte's job is written into
// the queue when the byte is taken; its words are then registered in the back.
// Reset (synchronous, active low) drops the open sequence and all queued
// words. Either side may stall without losing or repeating words.
module utf8_lenient_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);
  import u8dec_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  // byte classification and sequence state
  u8dec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // decoupling queue
  u8dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // result serializer
  u8dec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_ch    (out_ch)
  );

endmodule
